// ===== design/fmfd_pkg.sv =====
`timescale 1ns / 1ps

package fmfd_pkg;

   // Outcome of one flux interval
   localparam logic [1:0] BIT_ZERO    = 2'd0;
   localparam logic [1:0] BIT_ONE     = 2'd1;
   localparam logic [1:0] BIT_NONE    = 2'd2;
   localparam logic [1:0] BIT_GARBAGE = 2'd3;

   localparam logic [8:0] SUM_MAX           = 9'd511;
   localparam logic [3:0] BYTE_BITS         = 4'd8;
   localparam logic [7:0] CELL_PERIOD_RESET = 8'd64;

   localparam logic STATUS_BYTE      = 1'b0;
   localparam logic STATUS_LOCK_LOST = 1'b1;

   typedef struct packed {
      logic [1:0] code;
      logic       in_short;
      logic [8:0] short_sum;
   } cls_type;

endpackage

// ===== design/fmfd_classify.sv =====
`timescale 1ns / 1ps

module fmfd_classify (
   input  logic [7:0]       cell_period,
   input  logic [7:0]       interval,
   input  logic             in_short,
   input  logic [8:0]       short_sum,
   output fmfd_pkg::cls_type cls
);

   logic [9:0] triple;
   logic [5:0] p0;
   logic [7:0] p1;
   logic [8:0] p2;
   logic [9:0] sum_raw;
   logic [8:0] sum_sat;

   // 3c = c + 2c; thresholds are plain shifts of it
   assign triple  = {2'b00, cell_period} + {1'b0, cell_period, 1'b0};
   assign p0      = cell_period[7:2];
   assign p1      = triple[9:2];
   assign p2      = triple[9:1];
   assign sum_raw = {1'b0, short_sum} + {2'b00, interval};
   assign sum_sat = sum_raw[9] ? fmfd_pkg::SUM_MAX : sum_raw[8:0];

   always_comb begin
      cls.code      = fmfd_pkg::BIT_NONE;
      cls.in_short  = in_short;
      cls.short_sum = short_sum;
      if (in_short) begin
         if (sum_sat < {1'b0, p1}) begin
            cls.short_sum = sum_sat;
         end else begin
            cls.in_short  = 1'b0;
            cls.short_sum = 9'd0;
            cls.code      = (sum_sat > p2) ? fmfd_pkg::BIT_GARBAGE : fmfd_pkg::BIT_ONE;
         end
      end else if (interval < {2'b00, p0} || {1'b0, interval} > p2) begin
         cls.code = fmfd_pkg::BIT_GARBAGE;
      end else if (interval < p1) begin
         // short interval opens a sum
         cls.in_short  = 1'b1;
         cls.short_sum = {1'b0, interval};
      end else begin
         cls.code = fmfd_pkg::BIT_ZERO;
      end
   end

endmodule

// ===== design/fm_flux_interval_bit_decoder.sv =====
`timescale 1ns / 1ps

// FM flux interval decoder: one flux interval per item in, bytes out.
// An accepted item is registered in the input stage; any result it yields then
// loads the result register and is offered on rsp. Throughput: one item per
// cycle while rsp is not stalled; the decode step is a single compare/shift pass.
// Reset (synchronous, active high) empties both stages, drops lock and sets
// cell_period to 64 ticks.
module fm_flux_interval_bit_decoder (
   input  logic       clock,
   input  logic       reset,
   // config write: cell_period
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data,      // [7:0] cell_period
   // flux intervals in
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] interval
   input  logic       req_tlast,     // last_of_track
   // decoded bytes out
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] data_byte
   output logic       rsp_tuser      // [0] status
);

   logic [7:0] cell_period_ff;

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_interval_ff;
   logic       s1_last_ff;

   // decoder state
   logic [7:0] shift_bits_ff, shift_bits_in;
   logic [3:0] bits_held_ff, bits_held_in;
   logic       locked_ff, locked_in;
   logic [8:0] short_sum_ff, short_sum_in;
   logic       in_short_ff, in_short_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_status_ff, rsp_status_in;

   logic       s1_advance, s1_fire, req_fire;
   logic       has_result;
   logic [3:0] held_next;
   logic [7:0] shifted;
   fmfd_pkg::cls_type cls;

   assign csr_ready = 1'b1;

   // output slot frees when empty or being taken this cycle
   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;

   fmfd_classify u_classify (
      .cell_period  (cell_period_ff),
      .interval     (s1_interval_ff),
      .in_short     (in_short_ff),
      .short_sum    (short_sum_ff),
      .cls          (cls)
   );

   assign held_next = bits_held_ff + 4'd1;
   assign shifted   = {shift_bits_ff[6:0], (cls.code == fmfd_pkg::BIT_ONE)};

   always_comb begin
      shift_bits_in = shift_bits_ff;
      bits_held_in  = bits_held_ff;
      locked_in     = locked_ff;
      short_sum_in  = short_sum_ff;
      in_short_in   = in_short_ff;
      has_result    = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      if (s1_fire) begin
         short_sum_in = cls.short_sum;
         in_short_in  = cls.in_short;
         case (cls.code)
            fmfd_pkg::BIT_GARBAGE: begin
               // lock lost mid-byte reports the discard
               if (locked_ff && bits_held_ff != 4'd0) begin
                  has_result    = 1'b1;
                  rsp_data_in   = 8'd0;
                  rsp_status_in = fmfd_pkg::STATUS_LOCK_LOST;
               end
               locked_in     = 1'b0;
               bits_held_in  = 4'd0;
               shift_bits_in = 8'd0;
            end
            fmfd_pkg::BIT_ZERO, fmfd_pkg::BIT_ONE: begin
               if (!locked_ff) begin
                  // hunting: a 1 starts the byte
                  if (cls.code == fmfd_pkg::BIT_ONE) begin
                     locked_in     = 1'b1;
                     shift_bits_in = 8'd1;
                     bits_held_in  = 4'd1;
                  end
               end else begin
                  shift_bits_in = shifted;
                  bits_held_in  = held_next;
                  if (held_next >= fmfd_pkg::BYTE_BITS) begin
                     has_result    = 1'b1;
                     rsp_data_in   = shifted;
                     rsp_status_in = fmfd_pkg::STATUS_BYTE;
                     bits_held_in  = 4'd0;
                  end
               end
            end
            default: begin
            end
         endcase

         if (s1_last_ff) begin
            shift_bits_in = 8'd0;
            bits_held_in  = 4'd0;
            locked_in     = 1'b0;
            short_sum_in  = 9'd0;
            in_short_in   = 1'b0;
         end
      end
   end

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = s1_advance ? (s1_fire && has_result) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_period_ff <= fmfd_pkg::CELL_PERIOD_RESET;
         s1_valid_ff    <= 1'b0;
         shift_bits_ff  <= 8'd0;
         bits_held_ff   <= 4'd0;
         locked_ff      <= 1'b0;
         short_sum_ff   <= 9'd0;
         in_short_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cell_period_ff <= csr_data;
         end
         s1_valid_ff   <= s1_valid_in;
         shift_bits_ff <= shift_bits_in;
         bits_held_ff  <= bits_held_in;
         locked_ff     <= locked_in;
         short_sum_ff  <= short_sum_in;
         in_short_ff   <= in_short_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_interval_ff <= req_tdata;
         s1_last_ff     <= req_tlast;
      end
      if (s1_fire && has_result) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTH
   // a full byte always empties the bit counter
   a_held_below_byte: assert property (@(posedge clock) disable iff (reset)
      bits_held_ff < fmfd_pkg::BYTE_BITS)
      else $error("bits_held reached a full byte");

   a_hunting_empty: assert property (@(posedge clock) disable iff (reset)
      !locked_ff |-> (bits_held_ff == 4'd0 && shift_bits_ff == 8'd0))
      else $error("bits held while hunting");

   a_sum_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !in_short_ff |-> short_sum_ff == 9'd0)
      else $error("short sum left over outside a short run");

   a_lock_lost_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == fmfd_pkg::STATUS_LOCK_LOST) |-> rsp_data_ff == 8'd0)
      else $error("lock-lost item carries data");

   a_result_needs_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result with no item in the input stage");
`endif

endmodule
